@@ rtl/dcd_pkg.sv @@
// Shared constants for the directed cycle detector.
// Field widths, beat packing, request codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package dcd_pkg;

    // Default storage sizes
    localparam int unsigned MAX_VERTICES_DEF = 64;
    localparam int unsigned MAX_EDGES_DEF    = 256;

    // Field widths
    localparam int unsigned NV_W      = 7;   // num_vertices register
    localparam int unsigned VTX_W     = 6;   // edge_source / edge_target
    localparam int unsigned EDGE_W    = 2 * VTX_W;
    localparam int unsigned S_TDATA_W = 16;  // edge fields padded to whole bytes
    localparam int unsigned M_TDATA_W = 8;   // result flags padded to one byte

    localparam logic [NV_W-1:0] NV_RESET = 7'd64;

    // Request kinds carried in s_tuser
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

endpackage

@@ rtl/dcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the edge store and the search stack. No dependencies.
`timescale 1ns / 1ps

module dcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/directed_cycle_detect_top.sv @@
// Directed cycle detector: edge store plus depth-first search sequencer; uses dcd_pkg, dcd_ram.
// An add-edge beat leaves the block idle, so it is ready again the next cycle.
// An evaluate beat runs the search, scanning the edge store through its single read port,
// one edge per cycle per vertex, with a fetch state after each descent or return.
// Reset (rst_n, asynchronous) empties the edge store, clears all marks and the
// overflow flag, and sets num_vertices to 64; no clearing pass is needed.
`timescale 1ns / 1ps

module directed_cycle_detect_top #(
    parameter int unsigned MAX_VERTICES = dcd_pkg::MAX_VERTICES_DEF,
    parameter int unsigned MAX_EDGES    = dcd_pkg::MAX_EDGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dcd_pkg::NV_W-1:0]       cfg_wr_data,  // num_vertices
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcd_pkg::S_TDATA_W-1:0]  s_tdata,      // [5:0] edge_source, [11:6] edge_target
    input  logic                           s_tuser,      // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcd_pkg::M_TDATA_W-1:0]  m_tdata       // [0] cycle_found, [1] edges_dropped
);

    localparam int unsigned NVW  = dcd_pkg::NV_W;
    localparam int unsigned VTW  = dcd_pkg::VTX_W;
    localparam int unsigned VW   = $clog2(MAX_VERTICES);
    localparam int unsigned DW   = $clog2(MAX_VERTICES + 1);
    localparam int unsigned CW   = $clog2(MAX_EDGES + 1);
    localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned SAW  = $clog2(MAX_VERTICES);
    localparam int unsigned SEW  = VW + CW;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ROOT    = 6'b000010,
        S_FETCH   = 6'b000100,
        S_SCAN    = 6'b001000,
        S_RESTORE = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [NVW-1:0]             num_vertices_reg;
    logic [CW-1:0]              edge_count_reg, edge_count_next;
    logic                       overflow_reg, overflow_next;
    logic [MAX_VERTICES-1:0]    visited_reg, visited_next;
    logic [MAX_VERTICES-1:0]    on_stack_reg, on_stack_next;
    logic [DW-1:0]              depth_reg, depth_next;
    logic [VW-1:0]              cur_v_reg, cur_v_next;
    logic [CW-1:0]              cur_c_reg, cur_c_next;
    logic [NVW-1:0]             root_reg, root_next;
    logic                       cycle_reg, cycle_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_cycle_reg, m_cycle_next;
    logic                       m_dropped_reg, m_dropped_next;

    logic [NVW-1:0]             nv_eff;
    logic                       in_beat;
    logic [VTW-1:0]             in_src, in_dst;

    logic                       edge_wr_en;
    logic [EAW-1:0]             edge_rd_addr;
    logic [dcd_pkg::EDGE_W-1:0] edge_rd_data;
    logic [VTW-1:0]             e_src, e_dst;
    logic [VW-1:0]              e_dst_idx;
    logic                       e_match;

    logic                       stk_wr_en;
    logic [SEW-1:0]             stk_rd_data;

    // A register value above the vertex capacity acts as the capacity.
    assign nv_eff = (32'(num_vertices_reg) > MAX_VERTICES) ? NVW'(MAX_VERTICES)
                                                            : num_vertices_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_src   = s_tdata[VTW-1:0];
    assign in_dst   = s_tdata[2*VTW-1:VTW];

    assign edge_wr_en = in_beat && (s_tuser == dcd_pkg::REQ_ADD)
                        && (32'(edge_count_reg) < MAX_EDGES)
                        && ({1'b0, in_src} < nv_eff) && ({1'b0, in_dst} < nv_eff);

    // While scanning, the read for the following edge is already under way.
    assign edge_rd_addr = (state_reg == S_SCAN) ? EAW'(cur_c_reg + CW'(1)) : EAW'(cur_c_reg);

    assign e_src     = edge_rd_data[VTW-1:0];
    assign e_dst     = edge_rd_data[2*VTW-1:VTW];
    assign e_dst_idx = VW'(e_dst);
    assign e_match   = (32'(e_src) == 32'(cur_v_reg)) && ({1'b0, e_dst} < nv_eff);

    dcd_ram #(
        .WIDTH (dcd_pkg::EDGE_W),
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (EAW'(edge_count_reg)),
        .wr_data ({in_dst, in_src}),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    // The top of the stack lives in cur_v/cur_c; the RAM holds the entries below it.
    dcd_ram #(
        .WIDTH (SEW),
        .DEPTH (MAX_VERTICES),
        .AW    (SAW)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (SAW'(depth_reg - DW'(1))),
        .wr_data ({cur_v_reg, CW'(cur_c_reg + CW'(1))}),
        .rd_addr (SAW'(depth_reg - DW'(2))),
        .rd_data (stk_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        overflow_next   = overflow_reg;
        visited_next    = visited_reg;
        on_stack_next   = on_stack_reg;
        depth_next      = depth_reg;
        cur_v_next      = cur_v_reg;
        cur_c_next      = cur_c_reg;
        root_next       = root_reg;
        cycle_next      = cycle_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_cycle_next    = m_cycle_reg;
        m_dropped_next  = m_dropped_reg;
        stk_wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == dcd_pkg::REQ_EVAL)
                    begin
                        root_next  = '0;
                        cycle_next = 1'b0;
                        state_next = S_ROOT;
                    end
                    else if (edge_wr_en)
                    begin
                        edge_count_next = edge_count_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            S_ROOT:
            begin
                if (root_reg >= nv_eff)
                begin
                    state_next = S_DONE;
                end
                else if (visited_reg[VW'(root_reg)])
                begin
                    root_next = root_reg + NVW'(1);
                end
                else
                begin
                    visited_next[VW'(root_reg)]  = 1'b1;
                    on_stack_next[VW'(root_reg)] = 1'b1;
                    cur_v_next = VW'(root_reg);
                    cur_c_next = '0;
                    depth_next = DW'(1);
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cur_c_reg >= edge_count_reg)
                begin
                    // No edge left for this vertex: pop it.
                    on_stack_next[cur_v_reg] = 1'b0;
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        state_next = S_RESTORE;
                    end
                end
                else if (e_match && on_stack_reg[e_dst_idx])
                begin
                    // Back edge closes a cycle.
                    cycle_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (e_match && !visited_reg[e_dst_idx])
                begin
                    stk_wr_en = 1'b1;
                    visited_next[e_dst_idx]  = 1'b1;
                    on_stack_next[e_dst_idx] = 1'b1;
                    cur_v_next = e_dst_idx;
                    cur_c_next = '0;
                    depth_next = depth_reg + DW'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    cur_c_next = cur_c_reg + CW'(1);
                end
            end
            S_RESTORE:
            begin
                cur_v_next = stk_rd_data[SEW-1:CW];
                cur_c_next = stk_rd_data[CW-1:0];
                state_next = S_FETCH;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    m_cycle_next    = cycle_reg;
                    m_dropped_next  = overflow_reg;
                    visited_next    = '0;
                    on_stack_next   = '0;
                    edge_count_next = '0;
                    overflow_next   = 1'b0;
                    depth_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_vertices_reg <= dcd_pkg::NV_RESET;
            edge_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            visited_reg      <= '0;
            on_stack_reg     <= '0;
            depth_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                num_vertices_reg <= cfg_wr_data;
            end
            edge_count_reg <= edge_count_next;
            overflow_reg   <= overflow_next;
            visited_reg    <= visited_next;
            on_stack_reg   <= on_stack_next;
            depth_reg      <= depth_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg     <= cur_v_next;
        cur_c_reg     <= cur_c_next;
        root_reg      <= root_next;
        cycle_reg     <= cycle_next;
        m_cycle_reg   <= m_cycle_next;
        m_dropped_reg <= m_dropped_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dcd_pkg::M_TDATA_W - 2){1'b0}}, m_dropped_reg, m_cycle_reg};

endmodule

@@ test/tb_directed_cycle_detect_top.sv @@
// Self-checking testbench for the directed cycle detector.
// Each evaluate result is checked against a depth-first cycle predictor kept here.
// Depends on dcd_pkg and directed_cycle_detect_top.
`timescale 1ns / 1ps

module tb_directed_cycle_detect_top;

    localparam int unsigned STORE_DEPTH = dcd_pkg::MAX_EDGES_DEF;
    localparam int unsigned VTX_COUNT   = dcd_pkg::MAX_VERTICES_DEF;
    localparam int unsigned SETTLE      = 20;
    localparam int unsigned STALL_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 600;

    typedef struct packed {
        logic                      kind;
        logic [dcd_pkg::VTX_W-1:0] source;
        logic [dcd_pkg::VTX_W-1:0] target;
    } request_t;

    typedef struct packed {
        logic cycle_found;
        logic edges_dropped;
    } verdict_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [dcd_pkg::NV_W-1:0]      cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dcd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = dcd_pkg::REQ_ADD;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dcd_pkg::M_TDATA_W-1:0] m_tdata;

    request_t request_q[$];
    verdict_t verdicts_due[$];

    // Predictor state: configured vertex count and the stored edges.
    int unsigned               vertex_cfg = 32'(dcd_pkg::NV_RESET);
    logic [dcd_pkg::VTX_W-1:0] edge_from[STORE_DEPTH];
    logic [dcd_pkg::VTX_W-1:0] edge_to[STORE_DEPTH];
    int unsigned               edges_held = 0;
    logic                      edge_lost = 1'b0;

    logic        in_fire = 1'b0;
    logic        no_gaps = 1'b0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_pushed = 0;

    directed_cycle_detect_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic int unsigned active_vertices();
        return (vertex_cfg > VTX_COUNT) ? VTX_COUNT : vertex_cfg;
    endfunction

    // Depth-first walk with an explicit stack of (vertex, edge cursor) pairs;
    // it stops at the first edge that returns to a vertex still on the stack.
    function automatic logic find_cycle(int unsigned nv);
        bit          seen[VTX_COUNT];
        bit          on_path[VTX_COUNT];
        int unsigned path_vtx[VTX_COUNT];
        int unsigned path_cur[VTX_COUNT];
        int unsigned depth;
        int unsigned v;
        int unsigned c;
        int unsigned w;
        bit          hit;
        for (int i = 0; i < VTX_COUNT; i++)
        begin
            seen[i] = 1'b0;
            on_path[i] = 1'b0;
        end
        depth = 0;
        for (int unsigned root = 0; root < nv; root++)
        begin
            if (seen[root])
                continue;
            seen[root] = 1'b1;
            on_path[root] = 1'b1;
            path_vtx[0] = root;
            path_cur[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                v = path_vtx[depth-1];
                c = path_cur[depth-1];
                hit = 1'b0;
                w = 0;
                while (c < edges_held && !hit)
                begin
                    if (edge_from[c] == v && edge_to[c] < nv)
                    begin
                        w = 32'(edge_to[c]);
                        hit = 1'b1;
                    end
                    c++;
                end
                path_cur[depth-1] = c;
                if (hit)
                begin
                    if (on_path[w])
                        return 1'b1;
                    if (!seen[w])
                    begin
                        seen[w] = 1'b1;
                        on_path[w] = 1'b1;
                        path_vtx[depth] = w;
                        path_cur[depth] = 0;
                        depth++;
                    end
                end
                else
                begin
                    on_path[v] = 1'b0;
                    depth--;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic store_edge(input logic [dcd_pkg::VTX_W-1:0] src,
                              input logic [dcd_pkg::VTX_W-1:0] dst);
        int unsigned nv;
        nv = active_vertices();
        if (edges_held >= STORE_DEPTH || src >= nv || dst >= nv)
            edge_lost = 1'b1;
        else
        begin
            edge_from[edges_held] = src;
            edge_to[edges_held] = dst;
            edges_held++;
        end
    endtask

    task automatic push_edge(input int unsigned src, input int unsigned dst);
        request_t r;
        r.kind = dcd_pkg::REQ_ADD;
        r.source = src[dcd_pkg::VTX_W-1:0];
        r.target = dst[dcd_pkg::VTX_W-1:0];
        request_q = {request_q, r};
        items_pushed++;
    endtask

    // The edge fields are ignored on evaluate, so they carry random noise.
    task automatic push_evaluate();
        request_t    r;
        int unsigned noise_src;
        int unsigned noise_dst;
        noise_src = $urandom_range(63);
        noise_dst = $urandom_range(63);
        r.kind = dcd_pkg::REQ_EVAL;
        r.source = noise_src[dcd_pkg::VTX_W-1:0];
        r.target = noise_dst[dcd_pkg::VTX_W-1:0];
        request_q = {request_q, r};
        items_pushed++;
    endtask

    // Waits until every beat has gone in and every verdict has come out.
    task automatic settle_block();
        while (request_q.size() != 0 || s_tvalid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_vertices(input int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[dcd_pkg::NV_W-1:0];
        vertex_cfg = value & 32'h7f;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Source side: a beat stays up until taken, then the next one may follow a gap.
    always @(negedge clk)
    begin : drive_requests
        request_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_fire)
            s_tvalid <= 1'b1;
        else if (request_q.size() != 0 && (no_gaps || $urandom_range(99) >= 10))
        begin
            nxt = request_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= nxt.kind;
            s_tdata <= {{(dcd_pkg::S_TDATA_W-dcd_pkg::EDGE_W){1'b0}}, nxt.target, nxt.source};
        end
        else
            s_tvalid <= 1'b0;
        m_tready <= rst_n && (no_gaps || $urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin : observe
        verdict_t predicted;
        verdict_t due;
        logic     moved;
        moved = 1'b0;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            moved = 1'b1;
            if (s_tuser == dcd_pkg::REQ_ADD)
                store_edge(s_tdata[dcd_pkg::VTX_W-1:0],
                           s_tdata[dcd_pkg::EDGE_W-1:dcd_pkg::VTX_W]);
            else
            begin
                predicted.cycle_found = find_cycle(active_vertices());
                predicted.edges_dropped = edge_lost;
                verdicts_due = {verdicts_due, predicted};
                edges_held = 0;
                edge_lost = 1'b0;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            moved = 1'b1;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual cycle_found=%0b edges_dropped=%0b",
                         $time, m_tdata[0], m_tdata[1]);
                error_count++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (m_tdata[0] !== due.cycle_found)
                begin
                    $display("%0t: cycle_found expected %0b actual %0b",
                             $time, due.cycle_found, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[1] !== due.edges_dropped)
                begin
                    $display("%0t: edges_dropped expected %0b actual %0b",
                             $time, due.edges_dropped, m_tdata[1]);
                    error_count++;
                end
            end
        end
        if (moved)
            idle_cycles = 0;
        else if (rst_n)
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_directed_cycle_detect_top: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned nv;
        int unsigned rot;
        int unsigned n_edges;
        int unsigned back_at;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        int unsigned pick;
        int unsigned phase;
        int unsigned random_start;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset vertex count: self-loop, two-vertex cycle at the top, a chain with no cycle.
        push_edge(0, 0);
        push_evaluate();
        push_edge(63, 62);
        push_edge(62, 63);
        push_evaluate();
        push_edge(0, 1);
        push_edge(1, 2);
        push_edge(0, 2);
        push_evaluate();
        push_evaluate();
        settle_block();

        // No vertices: every edge is dropped and no cycle can be found.
        write_vertices(0);
        push_edge(0, 0);
        push_evaluate();
        settle_block();

        // Small graph with an out-of-range endpoint beside a real cycle.
        write_vertices(4);
        push_edge(5, 1);
        push_edge(1, 2);
        push_edge(2, 1);
        push_evaluate();
        settle_block();

        // Edges stored at eight vertices, then the count shrinks before evaluation.
        write_vertices(8);
        push_edge(6, 7);
        push_edge(7, 6);
        settle_block();
        write_vertices(4);
        push_evaluate();
        settle_block();

        // Register above range behaves as the full vertex count.
        write_vertices(127);
        push_edge(63, 0);
        push_edge(0, 63);
        push_evaluate();
        settle_block();

        write_vertices(1);
        push_edge(0, 0);
        push_evaluate();
        push_edge(0, 1);
        push_evaluate();
        settle_block();

        random_start = items_pushed;
        phase = 0;
        while (items_pushed - random_start < RANDOM_ITEMS)
        begin
            no_gaps = (phase >= 15 && phase < 26);
            if (phase == 6)
            begin
                // Fill the edge store past its end with an acyclic graph.
                write_vertices(64);
                for (int i = 0; i < STORE_DEPTH + 2; i++)
                begin
                    a = $urandom_range(62);
                    b = $urandom_range(63, a + 1);
                    push_edge(a, b);
                end
                push_evaluate();
            end
            else if (phase == 12)
            begin
                // One long chain drives the search stack to its full depth.
                write_vertices(64);
                for (int i = 0; i < VTX_COUNT - 1; i++)
                    push_edge(i, i + 1);
                if ($urandom_range(1))
                    push_edge(63, 0);
                push_evaluate();
            end
            else
            begin
                if (phase == 0 || $urandom_range(99) < 70)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        write_vertices(0);
                    else if (pick < 15)
                        write_vertices($urandom_range(127, 65));
                    else if (pick < 25)
                        write_vertices($urandom_range(64, 33));
                    else
                        write_vertices($urandom_range(12, 1));
                end
                nv = active_vertices();
                rot = (nv == 0) ? 0 : $urandom_range(nv - 1);
                n_edges = $urandom_range(10);
                back_at = ($urandom_range(99) < 40) ? $urandom_range(n_edges) : n_edges + 1;
                for (int unsigned i = 0; i <= n_edges; i++)
                begin
                    if (nv == 0 || $urandom_range(99) < 10)
                        push_edge($urandom_range(63), $urandom_range(63));
                    else
                    begin
                        a = $urandom_range(nv - 1);
                        b = $urandom_range(nv - 1);
                        if (a > b)
                        begin
                            t = a;
                            a = b;
                            b = t;
                        end
                        // Forward edges in a relabelled order keep the graph acyclic;
                        // the one reversed edge may close a cycle.
                        if (i == back_at)
                            push_edge((b + rot) % nv, (a + rot) % nv);
                        else if (i < n_edges)
                            push_edge((a + rot) % nv, (b + rot) % nv);
                    end
                end
                push_evaluate();
                if ($urandom_range(99) < 15)
                    push_evaluate();
            end
            settle_block();
            phase++;
        end
        no_gaps = 1'b0;

        settle_block();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb_directed_cycle_detect_top: clean");
        else
            $display("tb_directed_cycle_detect_top: errors");
        $finish;
    end

endmodule
